// File: rtl/array_doubly_linked_list_unit_macros.svh
// assertion macros for the array doubly linked list unit
// included by the rtl files that carry concurrent checks, no other dependencies
`ifndef ARRAY_DOUBLY_LINKED_LIST_UNIT_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ADLL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adll check failed");
`define ADLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adll check failed");
`else
`define ADLL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ADLL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/adll_pkg.sv
// shared constants and codes for the array doubly linked list unit
// no dependencies
package adll_pkg;
    localparam int NODES_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE    = 2'd1;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;
endpackage

// File: rtl/adll_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module adll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/array_doubly_linked_list_unit.sv
// Doubly linked list over a fixed pool of NODES entries, node 0 being the
// head. A valid insert passes through S_INS_A, S_INS_B and S_RESP, a valid
// erase through S_ERS and S_RESP; a rejected request goes to S_RESP. Traverse
// reads the head link in S_T_CHK, then offers one result per node from
// S_T_DATA while the output is free; an empty list answers through S_RESP.
// Each step is one registered read of the link memories followed by
// write-back through their single write ports. One item is in work at a
// time; a new item is taken once the last result of the previous one is in
// the output register, and output stalls lengthen each item.
// Node indices are handed out in order and never reused, so no clearing
// pass is needed after reset. Depends on adll_pkg, adll_ram and the
// assertion macro header.
`include "array_doubly_linked_list_unit_macros.svh"
module array_doubly_linked_list_unit
    import adll_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // node, value
    input  logic [((($clog2(NODES) + DATA_W) + 7) / 8) * 8 - 1:0] s_tdata,
    // operation
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, node_index, data
    output logic [((($clog2(NODES) + DATA_W + STATUS_W) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                  m_tlast
);
    localparam int NODE_W = $clog2(NODES);
    localparam int NF_W   = NODE_W + 1;
    localparam int OUT_W  = NODE_W + DATA_W + STATUS_W;
    localparam int M_W    = ((OUT_W + 7) / 8) * 8;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS_A  = 3'd1;
    localparam logic [2:0] S_INS_B  = 3'd2;
    localparam logic [2:0] S_ERS    = 3'd3;
    localparam logic [2:0] S_T_CHK  = 3'd4;
    localparam logic [2:0] S_T_DATA = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [NF_W-1:0]     next_free_reg, next_free_next;
    logic                head_written_reg, head_written_next;
    logic [NODE_W-1:0]   node_reg, node_next_v;
    logic [NODE_W-1:0]   after_reg, after_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [NODE_W-1:0]   count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [NODE_W-1:0]   m_index_reg, m_index_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    logic [NODE_W-1:0]   in_node;
    logic [DATA_W-1:0]   in_value;
    logic                in_accept;
    logic                out_free;
    logic                pool_full;
    logic                node_known;
    logic [NODE_W-1:0]   fresh;
    logic [NODE_W-1:0]   next_head;
    logic                trav_last;

    logic                rd_en;
    logic [NODE_W-1:0]   rd_addr;
    logic                nxt_we, prv_we, val_we;
    logic [NODE_W-1:0]   nxt_waddr, prv_waddr;
    logic [NODE_W-1:0]   nxt_wdata, prv_wdata;
    logic [NODE_W-1:0]   nxt_rdata, prv_rdata;
    logic [DATA_W-1:0]   val_rdata;

    assign in_node    = s_tdata[NODE_W-1:0];
    assign in_value   = s_tdata[NODE_W +: DATA_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign pool_full  = (next_free_reg >= NF_W'(NODES));
    assign node_known = ({1'b0, in_node} < next_free_reg);
    assign fresh      = next_free_reg[NODE_W-1:0];
    // head entry reads as zero until first written
    assign next_head  = head_written_reg ? nxt_rdata : '0;
    assign trav_last  = (nxt_rdata == '0) || (count_reg == NODE_W'(NODES - 2));

    adll_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_next_ram (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .re(rd_en), .raddr(rd_addr), .rdata(nxt_rdata)
    );

    adll_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prev_ram (
        .aclk(aclk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .re(rd_en), .raddr(rd_addr), .rdata(prv_rdata)
    );

    adll_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_value_ram (
        .aclk(aclk), .we(val_we), .waddr(fresh), .wdata(in_value),
        .re(rd_en), .raddr(rd_addr), .rdata(val_rdata)
    );

    always_comb begin
        state_next        = state_reg;
        next_free_next    = next_free_reg;
        head_written_next = head_written_reg;
        node_next_v       = node_reg;
        after_next        = after_reg;
        cur_next          = cur_reg;
        count_next        = count_reg;
        status_next       = status_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_status_next     = m_status_reg;
        m_index_next      = m_index_reg;
        m_data_next       = m_data_reg;
        m_last_next       = m_last_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;
        nxt_we            = 1'b0;
        nxt_waddr         = '0;
        nxt_wdata         = '0;
        prv_we            = 1'b0;
        prv_waddr         = '0;
        prv_wdata         = '0;
        val_we            = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    node_next_v = in_node;
                    case (s_tuser)
                        OP_INSERT: begin
                            if (pool_full) begin
                                status_next = ST_FULL;
                                node_next_v = '0;
                                state_next  = S_RESP;
                            end else if (!node_known) begin
                                status_next = ST_BAD;
                                state_next  = S_RESP;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = in_node;
                                val_we     = 1'b1;
                                state_next = S_INS_A;
                            end
                        end
                        OP_ERASE: begin
                            if (in_node == '0 || !node_known) begin
                                status_next = ST_BAD;
                                state_next  = S_RESP;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = in_node;
                                state_next = S_ERS;
                            end
                        end
                        OP_TRAVERSE: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_T_CHK;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_A: begin
                after_next = (node_reg == '0) ? next_head : nxt_rdata;
                nxt_we     = 1'b1;
                nxt_waddr  = fresh;
                nxt_wdata  = (node_reg == '0) ? next_head : nxt_rdata;
                prv_we     = 1'b1;
                prv_waddr  = fresh;
                prv_wdata  = node_reg;
                state_next = S_INS_B;
            end
            S_INS_B: begin
                nxt_we     = 1'b1;
                nxt_waddr  = node_reg;
                nxt_wdata  = fresh;
                prv_we     = (after_reg != '0);
                prv_waddr  = after_reg;
                prv_wdata  = fresh;
                if (node_reg == '0) begin
                    head_written_next = 1'b1;
                end
                next_free_next = next_free_reg + NF_W'(1);
                status_next    = ST_OK;
                node_next_v    = fresh;
                state_next     = S_RESP;
            end
            S_ERS: begin
                nxt_we     = 1'b1;
                nxt_waddr  = prv_rdata;
                nxt_wdata  = nxt_rdata;
                prv_we     = (nxt_rdata != '0);
                prv_waddr  = nxt_rdata;
                prv_wdata  = prv_rdata;
                if (prv_rdata == '0) begin
                    head_written_next = 1'b1;
                end
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_T_CHK: begin
                if (next_head == '0) begin
                    status_next = ST_EMPTY;
                    node_next_v = '0;
                    state_next  = S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = next_head;
                    cur_next   = next_head;
                    count_next = '0;
                    state_next = S_T_DATA;
                end
            end
            S_T_DATA: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_index_next  = cur_reg;
                    m_data_next   = val_rdata;
                    m_last_next   = trav_last;
                    if (trav_last) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = nxt_rdata;
                        cur_next   = nxt_rdata;
                        count_next = count_reg + NODE_W'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_index_next  = node_reg;
                    m_data_next   = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            next_free_reg    <= NF_W'(1);
            head_written_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            next_free_reg    <= next_free_next;
            head_written_reg <= head_written_next;
            m_valid_reg      <= m_valid_next;
        end
        node_reg     <= node_next_v;
        after_reg    <= after_next;
        cur_reg      <= cur_next;
        count_reg    <= count_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_W'({m_data_reg, m_index_reg, m_status_reg});

    `ADLL_ASSERT_SAME(a_pool_bound, aclk, aresetn, 1'b1, next_free_reg <= NF_W'(NODES))
    `ADLL_ASSERT_SAME(a_error_is_last, aclk, aresetn, m_valid_reg && m_status_reg != ST_OK, m_last_reg)
    `ADLL_ASSERT_NEXT(a_insert_bump, aclk, aresetn, state_reg == S_INS_B, next_free_reg == $past(next_free_reg) + NF_W'(1))
    `ADLL_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, in_accept && s_tuser != OP_UNUSED, state_reg != S_IDLE)
    `ADLL_ASSERT_SAME(a_walk_bound, aclk, aresetn, state_reg == S_T_DATA, count_reg <= NODE_W'(NODES - 2))
endmodule
